// ===== hw/rtl/ffss_pkg.sv =====
// Shared types and constants for the FAT12 file sector sequencer.
`timescale 1ns / 1ps

package ffss_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam logic [11:0] END_MARK     = 12'hFF8;
  localparam logic [15:0] ENTRY_MASK   = 16'h0FFF;

  // Request opcodes
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_OPEN  = 3'd1;
  localparam logic [2:0] OP_ROOT  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DATA_START = 2'd0;
  localparam logic [1:0] REG_SPC        = 2'd1;
  localparam logic [1:0] REG_ROOT_LBA   = 2'd2;
  localparam logic [1:0] REG_ROOT_BYTES = 2'd3;

  typedef enum logic [2:0] {
    C_LOAD,
    C_OPEN_FILE,
    C_OPEN_ROOT,
    C_READ,
    C_CLOSE,
    C_NOP
  } cls_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } bstate_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [12:0] fat_addr;
    logic [7:0]  fat_byte;
    logic [11:0] first_cluster;
    logic [31:0] file_size;
    logic        is_directory;
    logic [31:0] byte_count;
  } item_t;

  typedef struct packed {
    logic [31:0] chunk_lba;
    logic [8:0]  chunk_offset;
    logic [9:0]  chunk_len;
    logic        fetch_valid;
    logic [31:0] fetch_lba;
    logic        end_of_chain;
    logic [31:0] position_after;
    logic        status;
  } result_t;

  typedef struct packed {
    logic [31:0] data_start_lba;
    logic [7:0]  sectors_per_cluster;
    logic [31:0] root_dir_lba;
    logic [31:0] root_dir_bytes;
  } cfg_t;

  typedef struct packed {
    cls_t  cls;
    item_t item;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_status_t;

endpackage

// ===== hw/rtl/fat12_file_sector_sequencer.sv =====
// Top level of the FAT12 file sector sequencer: config registers, front and back ends.
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  ffss_pkg::item_t
//   result    out        result_valid/result_stall ffss_pkg::result_t
//   config    in         APB psel/penable/pwrite  paddr, pwdata, prdata
//
// In the back end each request passes an execute state, which reads the two FAT
// bytes of the current cluster from block memory, and a finish state, which
// updates the cursor. A new request is taken only as the last one finishes; a
// two-entry queue sits in front. Reset is synchronous and clears the cursor, queue
// pointers and result valid flag; the FAT store holds no reset value. A stalled
// result holds the back end, the queue keeps taking requests until it is full.
`timescale 1ns / 1ps

module fat12_file_sector_sequencer #(
  parameter int unsigned FAT_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  ffss_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_stall,
  output ffss_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  ffss_pkg::cfg_t      cfg;
  ffss_pkg::q_status_t q;
  logic                pop;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_start_lba      <= 32'd0;
      cfg.sectors_per_cluster <= 8'd1;
      cfg.root_dir_lba        <= 32'd0;
      cfg.root_dir_bytes      <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ffss_pkg::REG_DATA_START: cfg.data_start_lba      <= pwdata;
        ffss_pkg::REG_SPC:        cfg.sectors_per_cluster <= pwdata[7:0];
        ffss_pkg::REG_ROOT_LBA:   cfg.root_dir_lba        <= pwdata;
        ffss_pkg::REG_ROOT_BYTES: cfg.root_dir_bytes      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[3:2])
      ffss_pkg::REG_DATA_START: prdata = cfg.data_start_lba;
      ffss_pkg::REG_SPC:        prdata = {24'd0, cfg.sectors_per_cluster};
      ffss_pkg::REG_ROOT_LBA:   prdata = cfg.root_dir_lba;
      ffss_pkg::REG_ROOT_BYTES: prdata = cfg.root_dir_bytes;
      default:                  prdata = 32'd0;
    endcase
  end

  ffss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .pop        (pop),
    .q          (q)
  );

  ffss_back #(
    .FAT_BYTES (FAT_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q            (q),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Back end never takes requests in consecutive cycles
  a_pop_spacing: assert property (@(posedge clk) disable iff (rst) pop |=> !pop)
    else $error("back end popped two requests in a row");

  // Pop only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> q.valid)
    else $error("pop from empty queue");

  // A request with no cursor delivers nothing and fetches nothing
  a_no_cursor: assert property (@(posedge clk) disable iff (rst)
      (result_valid && result.status) |->
      (result.chunk_len == 10'd0 && !result.fetch_valid && !result.end_of_chain))
    else $error("no-cursor result carries data");

  // A fetch and an end of chain never appear together
  a_fetch_eoc: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> !(result.fetch_valid && result.end_of_chain))
    else $error("fetch with end of chain");

endmodule

// ===== hw/rtl/ffss_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module ffss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ffss_pkg::item_t     item,
  input  logic                pop,
  output ffss_pkg::q_status_t q
);

  localparam int unsigned QDEPTH = 2;

  ffss_pkg::q_entry_t entries [QDEPTH];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  ffss_pkg::cls_t     cls;

  // Decode the opcode into a request class
  always_comb begin
    case (item.opcode)
      ffss_pkg::OP_LOAD:  cls = ffss_pkg::C_LOAD;
      ffss_pkg::OP_OPEN:  cls = ffss_pkg::C_OPEN_FILE;
      ffss_pkg::OP_ROOT:  cls = ffss_pkg::C_OPEN_ROOT;
      ffss_pkg::OP_READ:  cls = ffss_pkg::C_READ;
      ffss_pkg::OP_CLOSE: cls = ffss_pkg::C_CLOSE;
      default:            cls = ffss_pkg::C_NOP;
    endcase
  end

  assign item_stall = (count == 2'(QDEPTH));
  assign push       = item_valid && !item_stall;

  // Store classified requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{cls: cls, item: item};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign q.valid = (count != 2'd0);
  assign q.entry = entries[rd_ptr];

endmodule

// ===== hw/rtl/ffss_back.sv =====
// Back end: FAT store, read cursor, chain walk and result register.
`timescale 1ns / 1ps

module ffss_back #(
  parameter int unsigned FAT_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  ffss_pkg::cfg_t      cfg,
  input  ffss_pkg::q_status_t q,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output ffss_pkg::result_t   result
);

  localparam int unsigned AW = $clog2(FAT_BYTES);

  logic [7:0] fat_mem [FAT_BYTES];

  ffss_pkg::bstate_t state, state_next;
  ffss_pkg::q_entry_t ent;

  // Cursor
  logic        cur_open, cur_open_next;
  logic        cur_root, cur_root_next;
  logic        cur_dir, cur_dir_next;
  logic [31:0] cur_cl, cur_cl_next;
  logic [31:0] start_cl, start_cl_next;
  logic [7:0]  sic, sic_next;
  logic [31:0] pos, pos_next;
  logic [31:0] len, len_next;

  // Values staged during execute
  logic [9:0]  take_r;
  logic [8:0]  off_r;
  logic [31:0] clba_r;
  logic [7:0]  rd0, rd1;

  logic              fin_go, mem_rd, mem_wr;
  ffss_pkg::result_t res_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ffss_pkg::S_IDLE: if (q.valid) state_next = ffss_pkg::S_EXEC;
      ffss_pkg::S_EXEC: state_next = ffss_pkg::S_FIN;
      ffss_pkg::S_FIN: begin
        if (fin_go) state_next = q.valid ? ffss_pkg::S_EXEC : ffss_pkg::S_IDLE;
      end
      default: state_next = ffss_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    fin_go = (state == ffss_pkg::S_FIN) && (!result_valid || !result_stall);
    pop    = q.valid && ((state == ffss_pkg::S_IDLE) || fin_go);
    mem_rd = (state == ffss_pkg::S_EXEC);
    mem_wr = (state == ffss_pkg::S_EXEC) && (ent.cls == ffss_pkg::C_LOAD) &&
             (32'(ent.item.fat_addr) < 32'(FAT_BYTES));
  end

  // FAT byte index of the current cluster entry
  logic [12:0] idx0, idx1;
  assign idx0 = {1'b0, cur_cl[11:0]} + {2'b0, cur_cl[11:1]};
  assign idx1 = idx0 + 13'd1;

  // FAT store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_wr) fat_mem[AW'(ent.item.fat_addr)] <= ent.item.fat_byte;
    if (mem_rd) begin
      rd0 <= fat_mem[AW'(idx0)];
      rd1 <= fat_mem[AW'(idx1)];
    end
  end

  // Execute: clamp the read and find the current sector
  logic [8:0]  off_e;
  logic [9:0]  lis_e;
  logic [31:0] left_e, cnt_e, mul_e;
  always_comb begin
    off_e  = pos[8:0];
    lis_e  = 10'(ffss_pkg::SECTOR_BYTES) - {1'b0, off_e};
    left_e = (len > pos) ? (len - pos) : 32'd0;
    cnt_e  = ent.item.byte_count;
    if (!cur_dir || len != 32'd0) begin
      if (cnt_e > left_e) cnt_e = left_e;
    end
    mul_e  = (cur_cl - 32'd2) * {24'd0, cfg.sectors_per_cluster};
  end

  always_ff @(posedge clk) begin
    if (pop) ent <= q.entry;
    if (state == ffss_pkg::S_EXEC) begin
      off_r  <= off_e;
      take_r <= (cnt_e < {22'd0, lis_e}) ? cnt_e[9:0] : lis_e;
      clba_r <= cur_root ? cur_cl : (cfg.data_start_lba + mul_e + {24'd0, sic});
    end
  end

  // Finish: walk the chain and form the result
  logic [8:0]  sic1;
  logic        wrap, at_end, open_file;
  logic [15:0] word;
  logic [11:0] chain;
  logic [31:0] nxt_cl, m_op, lba_f, pos_rd;
  logic [7:0]  nxt_sic;
  logic [9:0]  lis_f;
  always_comb begin
    open_file = (ent.cls == ffss_pkg::C_OPEN_FILE);
    sic1      = {1'b0, sic} + 9'd1;
    wrap      = (sic1 >= {1'b0, cfg.sectors_per_cluster});
    word      = {rd1, rd0};
    chain     = cur_cl[0] ? word[15:4] : 12'(word & ffss_pkg::ENTRY_MASK);
    nxt_cl    = wrap ? {20'd0, chain} : cur_cl;
    nxt_sic   = wrap ? 8'd0 : sic1[7:0];
    m_op      = open_file ? {20'd0, ent.item.first_cluster} : nxt_cl;
    lba_f     = cfg.data_start_lba + (m_op - 32'd2) * {24'd0, cfg.sectors_per_cluster} +
                (open_file ? 32'd0 : {24'd0, nxt_sic});
    lis_f     = 10'(ffss_pkg::SECTOR_BYTES) - {1'b0, off_r};
    at_end    = (take_r != 10'd0) && (take_r == lis_f);
    pos_rd    = pos + {22'd0, take_r};

    cur_open_next = cur_open;
    cur_root_next = cur_root;
    cur_dir_next  = cur_dir;
    cur_cl_next   = cur_cl;
    start_cl_next = start_cl;
    sic_next      = sic;
    pos_next      = pos;
    len_next      = len;
    res_next      = '0;

    case (ent.cls)
      ffss_pkg::C_OPEN_FILE: begin
        cur_open_next = 1'b1;
        cur_root_next = 1'b0;
        cur_dir_next  = ent.item.is_directory;
        start_cl_next = {20'd0, ent.item.first_cluster};
        cur_cl_next   = {20'd0, ent.item.first_cluster};
        sic_next      = 8'd0;
        pos_next      = 32'd0;
        len_next      = ent.item.file_size;
        res_next.fetch_valid = 1'b1;
        res_next.fetch_lba   = lba_f;
      end
      ffss_pkg::C_OPEN_ROOT: begin
        cur_open_next = 1'b1;
        cur_root_next = 1'b1;
        cur_dir_next  = 1'b1;
        start_cl_next = cfg.root_dir_lba;
        cur_cl_next   = cfg.root_dir_lba;
        sic_next      = 8'd0;
        pos_next      = 32'd0;
        len_next      = cfg.root_dir_bytes;
        res_next.fetch_valid = 1'b1;
        res_next.fetch_lba   = cfg.root_dir_lba;
      end
      ffss_pkg::C_READ: begin
        if (!cur_open) begin
          res_next.status = 1'b1;
        end else begin
          res_next.chunk_lba    = clba_r;
          res_next.chunk_offset = off_r;
          res_next.chunk_len    = take_r;
          pos_next              = pos_rd;
          if (at_end) begin
            if (cur_root) begin
              cur_cl_next          = cur_cl + 32'd1;
              res_next.fetch_valid = 1'b1;
              res_next.fetch_lba   = cur_cl + 32'd1;
            end else begin
              cur_cl_next = nxt_cl;
              sic_next    = nxt_sic;
              if (nxt_cl >= {20'd0, ffss_pkg::END_MARK}) begin
                len_next              = pos_rd;
                res_next.end_of_chain = 1'b1;
              end else begin
                res_next.fetch_valid = 1'b1;
                res_next.fetch_lba   = lba_f;
              end
            end
          end
        end
      end
      ffss_pkg::C_CLOSE: begin
        if (!cur_open) begin
          res_next.status = 1'b1;
        end else if (cur_root) begin
          pos_next             = 32'd0;
          cur_cl_next          = start_cl;
          res_next.fetch_valid = 1'b1;
          res_next.fetch_lba   = start_cl;
        end else begin
          cur_open_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res_next.position_after = pos_next;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (fin_go) result <= res_next;
  end

  // Update control and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ffss_pkg::S_IDLE;
      result_valid <= 1'b0;
      cur_open     <= 1'b0;
      cur_root     <= 1'b0;
      cur_dir      <= 1'b0;
      cur_cl       <= 32'd0;
      start_cl     <= 32'd0;
      sic          <= 8'd0;
      pos          <= 32'd0;
      len          <= 32'd0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        result_valid <= 1'b1;
        cur_open     <= cur_open_next;
        cur_root     <= cur_root_next;
        cur_dir      <= cur_dir_next;
        cur_cl       <= cur_cl_next;
        start_cl     <= start_cl_next;
        sic          <= sic_next;
        pos          <= pos_next;
        len          <= len_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
